// ===== sv/i2cmts_pkg.sv =====
// Shared types and codes for the I2C master transaction sequencer.
`default_nettype none
package i2cmts_pkg;

   // Item commands
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_EVENT = 2'd2;

   // Bus engine actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_TX      = 3'd1;
   localparam logic [2:0] ACT_START   = 3'd2;
   localparam logic [2:0] ACT_RESTART = 3'd3;
   localparam logic [2:0] ACT_RECV    = 3'd4;
   localparam logic [2:0] ACT_ACK     = 3'd5;
   localparam logic [2:0] ACT_STOP    = 3'd6;

   typedef struct packed {
      logic [1:0] cmd;
      logic       buffer_select;
      logic [3:0] byte_index;
      logic [7:0] byte_value;
      logic       is_read;
      logic [6:0] slave_address;
      logic [2:0] address_length;
      logic [4:0] data_length;
      logic       ack_status;
      logic [7:0] received_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [3:0] rx_index;
      logic       done_res;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SLAVE_W,
      PH_ADDR,
      PH_DATA,
      PH_RESTART,
      PH_SLAVE_R,
      PH_RECV,
      PH_READ,
      PH_STOP,
      PH_FINISHED
   } phase_type;

   typedef enum logic [2:0] {
      TX_NONE,
      TX_SLAVE_W,
      TX_SLAVE_R,
      TX_ADDR,
      TX_DATA
   } tx_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_CLEAR,
      CNT_INCR
   } cnt_op_type;

   // Controller to datapath
   typedef struct packed {
      logic [2:0] action;
      tx_sel_type tx_sel;
      cnt_op_type cnt_op;
      logic       latch_start;
      logic       load_en;
      logic       store_rx;
      logic       set_finished;
   } ctrl_type;

   // Datapath to controller
   typedef struct packed {
      logic read_mode;
      logic addr_last;
      logic data_last;
   } stat_type;

endpackage
`default_nettype wire

// ===== sv/i2cmts_ctrl.sv =====
// Phase state machine of the I2C transaction sequencer.
`default_nettype none
module i2cmts_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire i2cmts_pkg::req_type  req_data,
   input  wire i2cmts_pkg::stat_type stat,
   output i2cmts_pkg::ctrl_type      ctrl,
   output logic                      rsp_valid
);

   i2cmts_pkg::phase_type phase_ff, phase_in;
   logic busy_ff;
   logic rsp_valid_ff;
   logic accept;

   assign accept    = start & ~busy_ff;
   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cmts_pkg::PH_IDLE;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (req_data.cmd)
            i2cmts_pkg::CMD_START: begin
               phase_in = i2cmts_pkg::PH_SLAVE_W;
            end
            i2cmts_pkg::CMD_EVENT: begin
               unique case (phase_ff)
                  i2cmts_pkg::PH_SLAVE_W: phase_in = i2cmts_pkg::PH_ADDR;
                  i2cmts_pkg::PH_ADDR: begin
                     if (req_data.ack_status) begin
                        phase_in = i2cmts_pkg::PH_STOP;
                     end else if (stat.addr_last) begin
                        phase_in = stat.read_mode ? i2cmts_pkg::PH_RESTART
                                                  : i2cmts_pkg::PH_DATA;
                     end
                  end
                  i2cmts_pkg::PH_DATA: begin
                     if (req_data.ack_status || stat.data_last) begin
                        phase_in = i2cmts_pkg::PH_STOP;
                     end
                  end
                  i2cmts_pkg::PH_RESTART: phase_in = i2cmts_pkg::PH_SLAVE_R;
                  i2cmts_pkg::PH_SLAVE_R: phase_in = i2cmts_pkg::PH_RECV;
                  i2cmts_pkg::PH_RECV:    phase_in = i2cmts_pkg::PH_READ;
                  i2cmts_pkg::PH_READ: begin
                     phase_in = stat.data_last ? i2cmts_pkg::PH_FINISHED
                                               : i2cmts_pkg::PH_RECV;
                  end
                  i2cmts_pkg::PH_STOP:    phase_in = i2cmts_pkg::PH_FINISHED;
                  default:                phase_in = phase_ff;
               endcase
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Datapath commands
   always_comb begin
      ctrl = '{action:       i2cmts_pkg::ACT_NONE,
               tx_sel:       i2cmts_pkg::TX_NONE,
               cnt_op:       i2cmts_pkg::CNT_HOLD,
               latch_start:  1'b0,
               load_en:      1'b0,
               store_rx:     1'b0,
               set_finished: 1'b0};
      if (accept) begin
         unique case (req_data.cmd)
            i2cmts_pkg::CMD_LOAD: begin
               ctrl.load_en = 1'b1;
            end
            i2cmts_pkg::CMD_START: begin
               ctrl.latch_start = 1'b1;
               ctrl.cnt_op      = i2cmts_pkg::CNT_CLEAR;
               ctrl.action      = i2cmts_pkg::ACT_START;
            end
            i2cmts_pkg::CMD_EVENT: begin
               unique case (phase_ff)
                  i2cmts_pkg::PH_SLAVE_W: begin
                     ctrl.action = i2cmts_pkg::ACT_TX;
                     ctrl.tx_sel = i2cmts_pkg::TX_SLAVE_W;
                     ctrl.cnt_op = i2cmts_pkg::CNT_CLEAR;
                  end
                  i2cmts_pkg::PH_ADDR: begin
                     if (!req_data.ack_status) begin
                        ctrl.action = i2cmts_pkg::ACT_TX;
                        ctrl.tx_sel = i2cmts_pkg::TX_ADDR;
                        ctrl.cnt_op = stat.addr_last ? i2cmts_pkg::CNT_CLEAR
                                                     : i2cmts_pkg::CNT_INCR;
                     end
                  end
                  i2cmts_pkg::PH_DATA: begin
                     if (!req_data.ack_status) begin
                        ctrl.action = i2cmts_pkg::ACT_TX;
                        ctrl.tx_sel = i2cmts_pkg::TX_DATA;
                        ctrl.cnt_op = i2cmts_pkg::CNT_INCR;
                     end
                  end
                  i2cmts_pkg::PH_RESTART: begin
                     ctrl.action = i2cmts_pkg::ACT_RESTART;
                  end
                  i2cmts_pkg::PH_SLAVE_R: begin
                     ctrl.action = i2cmts_pkg::ACT_TX;
                     ctrl.tx_sel = i2cmts_pkg::TX_SLAVE_R;
                     ctrl.cnt_op = i2cmts_pkg::CNT_CLEAR;
                  end
                  i2cmts_pkg::PH_RECV: begin
                     ctrl.action = i2cmts_pkg::ACT_RECV;
                  end
                  i2cmts_pkg::PH_READ: begin
                     ctrl.store_rx = 1'b1;
                     ctrl.cnt_op   = i2cmts_pkg::CNT_INCR;
                     ctrl.action   = stat.data_last ? i2cmts_pkg::ACT_STOP
                                                    : i2cmts_pkg::ACT_ACK;
                  end
                  i2cmts_pkg::PH_STOP: begin
                     ctrl.action = i2cmts_pkg::ACT_STOP;
                  end
                  i2cmts_pkg::PH_FINISHED: begin
                     ctrl.set_finished = 1'b1;
                  end
                  default: ctrl.action = i2cmts_pkg::ACT_NONE;
               endcase
            end
            default: ctrl.action = i2cmts_pkg::ACT_NONE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== sv/i2cmts_datapath.sv =====
// Buffers, counters and result register of the I2C transaction sequencer.
`default_nettype none
module i2cmts_datapath #(
   parameter int ADDRESS_BYTES = 4,
   parameter int DATA_BYTES    = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire i2cmts_pkg::req_type  req_data,
   input  wire i2cmts_pkg::ctrl_type ctrl,
   output i2cmts_pkg::stat_type      stat,
   output i2cmts_pkg::rsp_type       rsp_data
);

   localparam int MAX_BYTES = (ADDRESS_BYTES > DATA_BYTES) ? ADDRESS_BYTES : DATA_BYTES;
   localparam int CW  = $clog2(MAX_BYTES + 1);
   localparam int ACW = $clog2(ADDRESS_BYTES + 1);
   localparam int DCW = $clog2(DATA_BYTES + 1);
   localparam int AIW = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;
   localparam int DIW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [ACW-1:0] addr_count_ff, addr_count_in;
   logic [DCW-1:0] data_count_ff, data_count_in;
   logic [7:0]     slave_ff, slave_in;
   logic           read_mode_ff, read_mode_in;
   logic           finished_ff, finished_in;
   logic [CW:0]    cnt_plus;
   logic [7:0]     tx_byte;
   i2cmts_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0] addr_buf [ADDRESS_BYTES];
   logic [7:0] data_buf [DATA_BYTES];

   assign cnt_plus       = {1'b0, cnt_ff} + 1'b1;
   assign stat.read_mode = read_mode_ff;
   assign stat.addr_last = cnt_plus >= (CW+1)'(addr_count_ff);
   assign stat.data_last = cnt_plus >= (CW+1)'(data_count_ff);

   // Lengths: zero counts as one, above the depth saturates
   always_comb begin
      addr_count_in = addr_count_ff;
      data_count_in = data_count_ff;
      slave_in      = slave_ff;
      read_mode_in  = read_mode_ff;
      if (ctrl.latch_start) begin
         read_mode_in = req_data.is_read;
         slave_in     = {req_data.slave_address, 1'b0};
         priority if (req_data.address_length == 3'd0) begin
            addr_count_in = ACW'(1);
         end else if (32'(req_data.address_length) > ADDRESS_BYTES) begin
            addr_count_in = ACW'(ADDRESS_BYTES);
         end else begin
            addr_count_in = ACW'(req_data.address_length);
         end
         priority if (req_data.data_length == 5'd0) begin
            data_count_in = DCW'(1);
         end else if (32'(req_data.data_length) > DATA_BYTES) begin
            data_count_in = DCW'(DATA_BYTES);
         end else begin
            data_count_in = DCW'(req_data.data_length);
         end
      end
   end

   always_comb begin
      unique case (ctrl.cnt_op)
         i2cmts_pkg::CNT_CLEAR: cnt_in = '0;
         i2cmts_pkg::CNT_INCR:  cnt_in = cnt_plus[CW-1:0];
         default:               cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      finished_in = finished_ff;
      priority if (ctrl.latch_start) begin
         finished_in = 1'b0;
      end else if (ctrl.set_finished) begin
         finished_in = 1'b1;
      end else begin
         finished_in = finished_ff;
      end
   end

   always_comb begin
      unique case (ctrl.tx_sel)
         i2cmts_pkg::TX_SLAVE_W: tx_byte = slave_ff;
         i2cmts_pkg::TX_SLAVE_R: tx_byte = slave_ff | 8'h01;
         i2cmts_pkg::TX_ADDR: begin
            tx_byte = (32'(cnt_ff) < ADDRESS_BYTES) ? addr_buf[AIW'(cnt_ff)] : 8'h00;
         end
         i2cmts_pkg::TX_DATA: begin
            tx_byte = (32'(cnt_ff) < DATA_BYTES) ? data_buf[DIW'(cnt_ff)] : 8'h00;
         end
         default: tx_byte = 8'h00;
      endcase
   end

   always_comb begin
      rsp_in.action   = ctrl.action;
      rsp_in.tx_byte  = tx_byte;
      rsp_in.rx_valid = ctrl.store_rx;
      rsp_in.rx_byte  = ctrl.store_rx ? req_data.received_byte : 8'h00;
      rsp_in.rx_index = ctrl.store_rx ? 4'(cnt_ff) : 4'h0;
      rsp_in.done_res = finished_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         addr_count_ff <= ACW'(1);
         data_count_ff <= DCW'(1);
         slave_ff      <= 8'h00;
         read_mode_ff  <= 1'b0;
         finished_ff   <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         addr_count_ff <= addr_count_in;
         data_count_ff <= data_count_in;
         slave_ff      <= slave_in;
         read_mode_ff  <= read_mode_in;
         finished_ff   <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Buffers: undefined until written, so no reset
   always_ff @(posedge clock) begin
      if (ctrl.load_en && !req_data.buffer_select &&
          32'(req_data.byte_index) < ADDRESS_BYTES) begin
         addr_buf[AIW'(req_data.byte_index)] <= req_data.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_en && req_data.buffer_select &&
          32'(req_data.byte_index) < DATA_BYTES) begin
         data_buf[DIW'(req_data.byte_index)] <= req_data.byte_value;
      end else if (ctrl.store_rx && 32'(cnt_ff) < DATA_BYTES) begin
         data_buf[DIW'(cnt_ff)] <= req_data.received_byte;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ===== sv/i2c_master_transaction_sequencer.sv =====
// Top level of the I2C master transaction sequencer.
//
// Drives a byte-level I2C bus engine through one register write or register
// read. Every beat taken on the request side (start high while busy is low)
// yields exactly one response beat, shown on rsp_data with rsp_valid high for
// a single cycle, in the cycle after acceptance; the receiver cannot stall it,
// so it must sample rsp_data whenever rsp_valid is set. busy is high only
// during reset and the cycle that follows it; after that a beat may be
// given every cycle. Load beats (cmd load) fill the address and data
// buffers; a start beat latches the transfer and returns a start action;
// each bus-completion beat returns the next action. Buffer entries have no
// reset: send only entries that have been loaded.
`default_nettype none
module i2c_master_transaction_sequencer #(
   parameter int ADDRESS_BYTES = 4,
   parameter int DATA_BYTES    = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire i2cmts_pkg::req_type req_data,
   output logic                     rsp_valid,
   output i2cmts_pkg::rsp_type      rsp_data
);

   // Command and status between the phase machine and the datapath
   i2cmts_pkg::ctrl_type ctrl;
   i2cmts_pkg::stat_type stat;

   i2cmts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .stat      (stat),
      .ctrl      (ctrl),
      .rsp_valid (rsp_valid)
   );

   // Buffers, byte counter, latched lengths and response register
   i2cmts_datapath #(
      .ADDRESS_BYTES (ADDRESS_BYTES),
      .DATA_BYTES    (DATA_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctrl     (ctrl),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ===== sv/i2cmts_checker.sv =====
// Port-level checks for the I2C master transaction sequencer, bound to the top.
`default_nettype none
module i2cmts_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire i2cmts_pkg::req_type req_data,
   input wire logic                rsp_valid,
   input wire i2cmts_pkg::rsp_type rsp_data
);

   // Every accepted beat answers on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("no response beat after an accepted request");

   // A start action only answers a start beat, and clears done
   a_start_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.action == i2cmts_pkg::ACT_START) |->
      ($past(req_data.cmd) == i2cmts_pkg::CMD_START && !rsp_data.done_res))
      else $error("start action without start beat or with done set");

   // Received bytes come only with ack or stop
   a_rx_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rx_valid) |->
      (rsp_data.action == i2cmts_pkg::ACT_ACK || rsp_data.action == i2cmts_pkg::ACT_STOP))
      else $error("received byte reported with wrong action");

   // tx_byte is zero unless transmitting
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.action != i2cmts_pkg::ACT_TX) |-> (rsp_data.tx_byte == 8'h00))
      else $error("tx_byte set without transmit action");

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_i2cmts_checker (.*);
`default_nettype wire
